[rtl/tswr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tswr_pkg
// Shared types and constants of the TCP sender window/retransmit core.
// ----------------------------------------------------------------------------
package tswr_pkg;

  localparam int QueueDepthDef = 64;
  localparam int MaxSegs       = 63;

  localparam logic [15:0] RtoRst      = 16'd1000;
  localparam logic [31:0] IseqRst     = 32'd0;
  localparam logic [10:0] MaxPayRst   = 11'd1000;
  localparam logic [15:0] CapacityRst = 16'd65535;

  // register index, paddr[3:2]
  localparam logic [1:0] RegInitialRto    = 2'd0;
  localparam logic [1:0] RegInitialSeqno  = 2'd1;
  localparam logic [1:0] RegMaxPayload    = 2'd2;
  localparam logic [1:0] RegStreamCap     = 2'd3;

  localparam logic [2:0] ActWrite = 3'd0;
  localparam logic [2:0] ActClose = 3'd1;
  localparam logic [2:0] ActFill  = 3'd2;
  localparam logic [2:0] ActAck   = 3'd3;
  localparam logic [2:0] ActTick  = 3'd4;
  localparam logic [2:0] ActEmpty = 3'd5;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] write_count;
    logic [31:0] ack_number;
    logic [15:0] peer_window_in;
    logic [15:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic        seg_valid;
    logic [31:0] seq_wrapped;
    logic        syn_flag;
    logic        fin_flag;
    logic [10:0] payload_len;
    logic        is_retransmit;
    logic [15:0] flight_bytes;
    logic [7:0]  retries;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_WRITE, OP_CLOSE, OP_FILL, OP_ACK, OP_TICK, OP_EMPTY, OP_NONE
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] write_count;
    logic [31:0] ack_number;
    logic [15:0] peer_window;
    logic [15:0] elapsed_ms;
  } cmd_t;

  typedef struct packed {
    logic [15:0] initial_rto;
    logic [31:0] initial_seqno;
    logic [10:0] max_payload;
    logic [15:0] stream_capacity;
  } cfg_t;

  // outstanding segment entry
  typedef struct packed {
    logic [63:0] start;
    logic        fin;
    logic        syn;
    logic [10:0] pay;
  } pend_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACK_UNWRAP, ST_ACK_CMP, ST_POP_RD, ST_POP_CHK, ST_ACK_DONE,
    ST_FILL, ST_TICK_ADD, ST_TICK_CHK, ST_EMPTY, ST_STATUS
  } state_e;

endpackage

[rtl/tcp_sender_window_retransmit_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_sender_window_retransmit_core
// TCP sender on segment descriptors: window fill, ack pops, retransmit timer.
//
//   channel  direction  handshake            payload
//   in       input      in_valid_i/stall_o   tswr_pkg::in_item_t
//   out      output     out_valid_o/stall_i  tswr_pkg::out_item_t
//   cfg      input      APB psel/penable     4 x 32-bit registers
//
// Write, close and unknown actions go straight to the status beat. Empty sends
// one segment beat first; tick may send a retransmit; fill sends segments.
// Ack pops entries, then fills; an ack beyond next seqno goes to status.
// Each pop passes ST_POP_RD, then ST_POP_CHK, for the registered queue read.
// No clearing pass after reset; the queue is only read at occupied slots.
// A stalled output holds the sequencer; the 2-deep input queue then fills.
// ----------------------------------------------------------------------------
module tcp_sender_window_retransmit_core #(
  parameter int QueueDepth = tswr_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tswr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tswr_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  tswr_pkg::cfg_t cfg_q;
  tswr_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_pop, wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.initial_rto     <= tswr_pkg::RtoRst;
      cfg_q.initial_seqno   <= tswr_pkg::IseqRst;
      cfg_q.max_payload     <= tswr_pkg::MaxPayRst;
      cfg_q.stream_capacity <= tswr_pkg::CapacityRst;
    end else if (wr_en) begin
      case (paddr[3:2])
        tswr_pkg::RegInitialRto:   cfg_q.initial_rto     <= pwdata[15:0];
        tswr_pkg::RegInitialSeqno: cfg_q.initial_seqno   <= pwdata;
        tswr_pkg::RegMaxPayload:   cfg_q.max_payload     <= pwdata[10:0];
        tswr_pkg::RegStreamCap:    cfg_q.stream_capacity <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tswr_pkg::RegInitialRto:   prdata = {16'd0, cfg_q.initial_rto};
      tswr_pkg::RegInitialSeqno: prdata = cfg_q.initial_seqno;
      tswr_pkg::RegMaxPayload:   prdata = {21'd0, cfg_q.max_payload};
      tswr_pkg::RegStreamCap:    prdata = {16'd0, cfg_q.stream_capacity};
      default:                   prdata = 32'd0;
    endcase
  end

  tswr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  tswr_back #(.QueueDepth(QueueDepth)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

[rtl/tswr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tswr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tswr_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tswr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tswr_front
// Accepts input beats, decodes the action and queues commands (2 deep).
// ----------------------------------------------------------------------------
module tswr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tswr_pkg::in_item_t in_data_i,
  output logic               cmd_valid_o,
  output tswr_pkg::cmd_t     cmd_o,
  input  logic               cmd_pop_i
);

  tswr_pkg::cmd_t fifo_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           push, pop;
  tswr_pkg::cmd_t cmd_new;

  always_comb begin
    cmd_new.write_count = in_data_i.write_count;
    cmd_new.ack_number  = in_data_i.ack_number;
    cmd_new.peer_window = in_data_i.peer_window_in;
    cmd_new.elapsed_ms  = in_data_i.elapsed_ms;
    case (in_data_i.action)
      tswr_pkg::ActWrite: cmd_new.op = tswr_pkg::OP_WRITE;
      tswr_pkg::ActClose: cmd_new.op = tswr_pkg::OP_CLOSE;
      tswr_pkg::ActFill:  cmd_new.op = tswr_pkg::OP_FILL;
      tswr_pkg::ActAck:   cmd_new.op = tswr_pkg::OP_ACK;
      tswr_pkg::ActTick:  cmd_new.op = tswr_pkg::OP_TICK;
      tswr_pkg::ActEmpty: cmd_new.op = tswr_pkg::OP_EMPTY;
      default:            cmd_new.op = tswr_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/tswr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tswr_back
// Sender sequencer: buffer accounting, segment fill, ack pops, retransmit
// timer, and the result register.
// ----------------------------------------------------------------------------
module tswr_back #(
  parameter int QueueDepth = tswr_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tswr_pkg::cfg_t      cfg_i,
  input  logic                cmd_valid_i,
  input  tswr_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tswr_pkg::out_item_t out_data_o
);

  localparam int AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CW = $clog2(QueueDepth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(QueueDepth - 1);
  localparam logic [CW-1:0] Full    = CW'(QueueDepth);
  localparam int PW = $bits(tswr_pkg::pend_t);

  tswr_pkg::state_e state_q, state_d;
  logic [63:0] next_q, next_d;
  logic [15:0] inflight_q, inflight_d;
  logic        syn_sent_q, syn_sent_d, fin_sent_q, fin_sent_d;
  logic [15:0] peer_q, peer_d;
  logic [15:0] buf_q, buf_d;
  logic        closed_q, closed_d;
  logic [31:0] rto_q, rto_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic        running_q, running_d;
  logic [7:0]  retries_q, retries_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [5:0]  sent_q, sent_d;
  logic        popped_q, popped_d;
  logic [63:0] abs_ack_q, abs_ack_d;
  logic [15:0] win_q, win_d;
  logic [15:0] ms_q, ms_d;
  logic        out_valid_q, out_valid_d;
  tswr_pkg::out_item_t out_q, out_d;

  logic          ram_we;
  tswr_pkg::pend_t ram_wdata, ram_rdata;
  logic [PW-1:0] ram_rbits;

  tswr_ram #(.Width(PW), .Depth(QueueDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(ram_wdata),
    .raddr_i(head_q),
    .rdata_o(ram_rbits)
  );
  assign ram_rdata = tswr_pkg::pend_t'(ram_rbits);

  // fill datapath
  logic [15:0] win, room, pay, buf_left, room_w;
  logic        syn_b, fin_b, fill_go;
  logic [16:0] used, seg_len;
  // ack datapath
  logic [31:0] off, nlo, hi, dgt, dlt;
  logic [63:0] ent_end;
  logic [11:0] ent_len;
  logic [32:0] el_sum;
  logic        out_free;

  always_comb begin
    win     = (peer_q == 16'd0) ? 16'd1 : peer_q;
    syn_b   = !syn_sent_q;
    room    = win - inflight_q - {15'd0, syn_b};
    pay     = {5'd0, cfg_i.max_payload};
    if (room < pay) pay = room;
    if (buf_q < pay) pay = buf_q;
    buf_left = buf_q - pay;
    used    = {1'b0, inflight_q} + {16'd0, syn_b} + {1'b0, pay};
    fin_b   = !fin_sent_q && closed_q && (buf_left == 16'd0) && (used < {1'b0, win});
    seg_len = used - {1'b0, inflight_q} + {16'd0, fin_b};
    fill_go = (inflight_q < win) && (sent_q < 6'(tswr_pkg::MaxSegs)) && (count_q < Full);

    off = cmd_i.ack_number - cfg_i.initial_seqno;
    nlo = next_q[31:0];
    hi  = next_q[63:32];
    dgt = off - nlo;
    dlt = nlo - off;

    ent_len = {1'b0, ram_rdata.pay} + {11'd0, ram_rdata.syn} + {11'd0, ram_rdata.fin};
    ent_end = ram_rdata.start + {52'd0, ent_len};

    el_sum   = {1'b0, elapsed_q} + {17'd0, ms_q};
    room_w   = cfg_i.stream_capacity - buf_q;
    out_free = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    state_d    = state_q;
    next_d     = next_q;
    inflight_d = inflight_q;
    syn_sent_d = syn_sent_q;
    fin_sent_d = fin_sent_q;
    peer_d     = peer_q;
    buf_d      = buf_q;
    closed_d   = closed_q;
    rto_d      = rto_q;
    elapsed_d  = elapsed_q;
    running_d  = running_q;
    retries_d  = retries_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    sent_d     = sent_q;
    popped_d   = popped_q;
    abs_ack_d  = abs_ack_q;
    win_d      = win_q;
    ms_d       = ms_q;
    out_d      = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_pop_o  = 1'b0;
    ram_we     = 1'b0;
    ram_wdata.start = next_q;
    ram_wdata.syn   = syn_b;
    ram_wdata.fin   = fin_b;
    ram_wdata.pay   = pay[10:0];

    case (state_q)
      tswr_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          sent_d    = 6'd0;
          win_d     = cmd_i.peer_window;
          ms_d      = cmd_i.elapsed_ms;
          case (cmd_i.op)
            tswr_pkg::OP_WRITE: begin
              if (!closed_q) begin
                if (cfg_i.stream_capacity <= buf_q) begin
                  buf_d = buf_q;
                end else if (cmd_i.write_count < room_w) begin
                  buf_d = buf_q + cmd_i.write_count;
                end else begin
                  buf_d = cfg_i.stream_capacity;
                end
              end
              state_d = tswr_pkg::ST_STATUS;
            end
            tswr_pkg::OP_CLOSE: begin
              closed_d = 1'b1;
              state_d  = tswr_pkg::ST_STATUS;
            end
            tswr_pkg::OP_FILL:  state_d = tswr_pkg::ST_FILL;
            tswr_pkg::OP_ACK: begin
              // nearest absolute value to next seqno
              abs_ack_d = {hi, off};
              if (off > nlo && dgt > 32'h8000_0000 && hi != 32'd0) begin
                abs_ack_d = {hi - 32'd1, off};
              end else if (off < nlo && dlt > 32'h8000_0000) begin
                abs_ack_d = {hi + 32'd1, off};
              end
              state_d = tswr_pkg::ST_ACK_CMP;
            end
            tswr_pkg::OP_TICK:  state_d = tswr_pkg::ST_TICK_ADD;
            tswr_pkg::OP_EMPTY: state_d = tswr_pkg::ST_EMPTY;
            default:            state_d = tswr_pkg::ST_STATUS;
          endcase
        end
      end
      tswr_pkg::ST_ACK_UNWRAP: state_d = tswr_pkg::ST_ACK_CMP;
      tswr_pkg::ST_ACK_CMP: begin
        popped_d = 1'b0;
        state_d  = (abs_ack_q <= next_q) ? tswr_pkg::ST_POP_RD : tswr_pkg::ST_STATUS;
      end
      tswr_pkg::ST_POP_RD: begin
        // head entry shows up on the RAM output next cycle
        state_d = (count_q != '0) ? tswr_pkg::ST_POP_CHK : tswr_pkg::ST_ACK_DONE;
      end
      tswr_pkg::ST_POP_CHK: begin
        if (ent_end > abs_ack_q) begin
          state_d = tswr_pkg::ST_ACK_DONE;
        end else begin
          popped_d   = 1'b1;
          inflight_d = inflight_q - {4'd0, ent_len};
          head_d     = (head_q == LastIdx) ? '0 : head_q + AW'(1);
          count_d    = count_q - CW'(1);
          state_d    = tswr_pkg::ST_POP_RD;
        end
      end
      tswr_pkg::ST_ACK_DONE: begin
        if (popped_q) begin
          retries_d = 8'd0;
          rto_d     = {16'd0, cfg_i.initial_rto};
          running_d = 1'b1;
          elapsed_d = 32'd0;
        end
        if (inflight_q == 16'd0) running_d = 1'b0;
        peer_d  = win_q;
        state_d = tswr_pkg::ST_FILL;
      end
      tswr_pkg::ST_FILL: begin
        if (!fill_go || seg_len == 17'd0) begin
          state_d = tswr_pkg::ST_STATUS;
        end else if (out_free) begin
          ram_we     = 1'b1;
          next_d     = next_q + {47'd0, seg_len};
          inflight_d = inflight_q + seg_len[15:0];
          buf_d      = buf_left;
          if (syn_b) syn_sent_d = 1'b1;
          if (fin_b) fin_sent_d = 1'b1;
          if (!running_q) begin
            running_d = 1'b1;
            elapsed_d = 32'd0;
          end
          tail_d  = (tail_q == LastIdx) ? '0 : tail_q + AW'(1);
          count_d = count_q + CW'(1);
          sent_d  = sent_q + 6'd1;
          out_valid_d         = 1'b1;
          out_d.seg_valid     = 1'b1;
          out_d.seq_wrapped   = cfg_i.initial_seqno + next_q[31:0];
          out_d.syn_flag      = syn_b;
          out_d.fin_flag      = fin_b;
          out_d.payload_len   = pay[10:0];
          out_d.is_retransmit = 1'b0;
          out_d.flight_bytes  = inflight_q + seg_len[15:0];
          out_d.retries       = retries_q;
          out_d.last          = 1'b0;
        end
      end
      tswr_pkg::ST_TICK_ADD: begin
        if (running_q) begin
          elapsed_d = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
          state_d   = tswr_pkg::ST_TICK_CHK;
        end else begin
          state_d = tswr_pkg::ST_STATUS;
        end
      end
      tswr_pkg::ST_TICK_CHK: begin
        if (elapsed_q >= rto_q && count_q != '0) begin
          if (out_free) begin
            retries_d = retries_q;
            if (peer_q != 16'd0) begin
              if (retries_q != 8'hFF) retries_d = retries_q + 8'd1;
              rto_d = rto_q[31] ? 32'hFFFF_FFFF : {rto_q[30:0], 1'b0};
            end
            elapsed_d           = 32'd0;
            out_valid_d         = 1'b1;
            out_d.seg_valid     = 1'b1;
            out_d.seq_wrapped   = cfg_i.initial_seqno + ram_rdata.start[31:0];
            out_d.syn_flag      = ram_rdata.syn;
            out_d.fin_flag      = ram_rdata.fin;
            out_d.payload_len   = ram_rdata.pay;
            out_d.is_retransmit = 1'b1;
            out_d.flight_bytes  = inflight_q;
            out_d.retries       = retries_d;
            out_d.last          = 1'b0;
            state_d             = tswr_pkg::ST_STATUS;
          end
        end else begin
          state_d = tswr_pkg::ST_STATUS;
        end
      end
      tswr_pkg::ST_EMPTY: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.seg_valid     = 1'b1;
          out_d.seq_wrapped   = cfg_i.initial_seqno + next_q[31:0];
          out_d.syn_flag      = 1'b0;
          out_d.fin_flag      = 1'b0;
          out_d.payload_len   = 11'd0;
          out_d.is_retransmit = 1'b0;
          out_d.flight_bytes  = inflight_q;
          out_d.retries       = retries_q;
          out_d.last          = 1'b0;
          state_d             = tswr_pkg::ST_STATUS;
        end
      end
      tswr_pkg::ST_STATUS: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.seg_valid     = 1'b0;
          out_d.seq_wrapped   = cfg_i.initial_seqno + next_q[31:0];
          out_d.syn_flag      = 1'b0;
          out_d.fin_flag      = 1'b0;
          out_d.payload_len   = 11'd0;
          out_d.is_retransmit = 1'b0;
          out_d.flight_bytes  = inflight_q;
          out_d.retries       = retries_q;
          out_d.last          = 1'b1;
          state_d             = tswr_pkg::ST_IDLE;
        end
      end
      default: state_d = tswr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tswr_pkg::ST_IDLE;
      next_q      <= 64'd0;
      inflight_q  <= 16'd0;
      syn_sent_q  <= 1'b0;
      fin_sent_q  <= 1'b0;
      peer_q      <= 16'd1;
      buf_q       <= 16'd0;
      closed_q    <= 1'b0;
      rto_q       <= {16'd0, tswr_pkg::RtoRst};
      elapsed_q   <= 32'd0;
      running_q   <= 1'b0;
      retries_q   <= 8'd0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      sent_q      <= 6'd0;
      popped_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_q      <= next_d;
      inflight_q  <= inflight_d;
      syn_sent_q  <= syn_sent_d;
      fin_sent_q  <= fin_sent_d;
      peer_q      <= peer_d;
      buf_q       <= buf_d;
      closed_q    <= closed_d;
      rto_q       <= rto_d;
      elapsed_q   <= elapsed_d;
      running_q   <= running_d;
      retries_q   <= retries_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      sent_q      <= sent_d;
      popped_q    <= popped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    abs_ack_q <= abs_ack_d;
    win_q     <= win_d;
    ms_q      <= ms_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the TCP sender core against a behavioral model of its segment
// engine: directed corner cases, then randomized connection traffic under
// several idle/stall mixes, with register changes between phases.
// ----------------------------------------------------------------------------
module testbench;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  tswr_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  tswr_pkg::out_item_t out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  tcp_sender_window_retransmit_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // sender model state
  logic [15:0] m_rto_init;
  logic [31:0] m_iseq;
  logic [10:0] m_max_pay;
  logic [15:0] m_cap;
  logic [63:0] m_next;
  logic [31:0] m_flight;
  bit          m_syn_sent, m_fin_sent, m_closed, m_tmr_on;
  logic [31:0] m_win, m_buf, m_rto, m_tmr;
  logic [7:0]  m_retries;
  logic [63:0] m_pend_start[$];
  logic [12:0] m_pend_lf[$];

  tswr_pkg::out_item_t expected_segs[$];
  int          mismatches = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_off = 1'b0;

  function automatic logic [31:0] wrap_abs(logic [63:0] a);
    return m_iseq + a[31:0];
  endfunction

  function automatic void push_seg(bit valid, logic [31:0] seq, logic [12:0] lf,
                                   bit retx, bit lst);
    tswr_pkg::out_item_t o;
    o.seg_valid = valid;
    o.seq_wrapped = seq;
    o.syn_flag = lf[11];
    o.fin_flag = lf[12];
    o.payload_len = lf[10:0];
    o.is_retransmit = retx;
    o.flight_bytes = m_flight[15:0];
    o.retries = m_retries;
    o.last = lst;
    expected_segs.push_back(o);
  endfunction

  function automatic void model_fill();
    logic [31:0] win, syn, pay, room, fin, len;
    int sent;
    win = (m_win != 32'd0) ? m_win : 32'd1;
    sent = 0;
    while (m_flight < win && sent < tswr_pkg::MaxSegs &&
           m_pend_lf.size() < tswr_pkg::QueueDepthDef) begin
      syn = m_syn_sent ? 32'd0 : 32'd1;
      pay = {21'd0, m_max_pay};
      room = win - m_flight - syn;
      fin = 32'd0;
      if (room < pay) pay = room;
      if (m_buf < pay) pay = m_buf;
      m_buf -= pay;
      if (!m_fin_sent && m_closed && m_buf == 32'd0 && m_flight + syn + pay < win)
        fin = 32'd1;
      len = syn + pay + fin;
      if (len == 32'd0) break;
      if (syn != 32'd0) m_syn_sent = 1'b1;
      if (fin != 32'd0) m_fin_sent = 1'b1;
      if (!m_tmr_on) begin
        m_tmr_on = 1'b1;
        m_tmr = 32'd0;
      end
      m_pend_start.push_back(m_next);
      m_pend_lf.push_back({fin[0], syn[0], pay[10:0]});
      m_flight += len;
      push_seg(1'b1, wrap_abs(m_next), {fin[0], syn[0], pay[10:0]}, 1'b0, 1'b0);
      m_next += {32'd0, len};
      sent++;
    end
  endfunction

  function automatic logic [31:0] lf_len(logic [12:0] lf);
    return {21'd0, lf[10:0]} + {31'd0, lf[11]} + {31'd0, lf[12]};
  endfunction

  function automatic void model_step(tswr_pkg::in_item_t it);
    logic [31:0] room, off, wc, ms;
    logic [63:0] c;
    bit popped;
    wc = {16'd0, it.write_count};
    ms = {16'd0, it.elapsed_ms};
    case (it.action)
      tswr_pkg::ActWrite: begin
        if (!m_closed) begin
          room = ({16'd0, m_cap} > m_buf) ? {16'd0, m_cap} - m_buf : 32'd0;
          m_buf += (wc < room) ? wc : room;
        end
      end
      tswr_pkg::ActClose: m_closed = 1'b1;
      tswr_pkg::ActFill: model_fill();
      tswr_pkg::ActAck: begin
        off = it.ack_number - m_iseq;
        c = {m_next[63:32], 32'd0} + {32'd0, off};
        if (c > m_next && c - m_next > 64'h8000_0000 && c >= 64'h1_0000_0000)
          c -= 64'h1_0000_0000;
        else if (c < m_next && m_next - c > 64'h8000_0000)
          c += 64'h1_0000_0000;
        if (c <= m_next) begin
          popped = 1'b0;
          while (m_pend_lf.size() > 0) begin
            if (m_pend_start[0] + {32'd0, lf_len(m_pend_lf[0])} > c) break;
            popped = 1'b1;
            m_flight -= lf_len(m_pend_lf[0]);
            void'(m_pend_start.pop_front());
            void'(m_pend_lf.pop_front());
          end
          if (popped) begin
            m_retries = 8'd0;
            m_rto = {16'd0, m_rto_init};
            m_tmr_on = 1'b1;
            m_tmr = 32'd0;
          end
          if (m_flight == 32'd0) m_tmr_on = 1'b0;
          m_win = {16'd0, it.peer_window_in};
          model_fill();
        end
      end
      tswr_pkg::ActTick: begin
        if (m_tmr_on) begin
          m_tmr = (m_tmr > 32'hFFFF_FFFF - ms) ? 32'hFFFF_FFFF : m_tmr + ms;
          if (m_tmr >= m_rto && m_pend_lf.size() > 0) begin
            if (m_win > 32'd0) begin
              if (m_retries < 8'd255) m_retries++;
              m_rto = (m_rto > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : {m_rto[30:0], 1'b0};
            end
            m_tmr = 32'd0;
            push_seg(1'b1, wrap_abs(m_pend_start[0]), m_pend_lf[0], 1'b1, 1'b0);
          end
        end
      end
      tswr_pkg::ActEmpty: push_seg(1'b1, wrap_abs(m_next), '0, 1'b0, 1'b0);
      default: ;
    endcase
    push_seg(1'b0, wrap_abs(m_next), '0, 1'b0, 1'b1);
  endfunction

  // driving; valid drops only for idle cycles, so back-to-back beats keep it high
  task automatic send_item(tswr_pkg::in_item_t it);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model_step(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      tswr_pkg::RegInitialRto: m_rto_init = val[15:0];
      tswr_pkg::RegInitialSeqno: m_iseq = val;
      tswr_pkg::RegMaxPayload: m_max_pay = val[10:0];
      default: m_cap = val[15:0];
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_segs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic tswr_pkg::in_item_t mk(logic [2:0] act, logic [15:0] wc,
                                            logic [31:0] ackn, logic [15:0] win,
                                            logic [15:0] ms);
    tswr_pkg::in_item_t it;
    it.action = act;
    it.write_count = wc;
    it.ack_number = ackn;
    it.peer_window_in = win;
    it.elapsed_ms = ms;
    return it;
  endfunction

  // ack at an outstanding segment start or next seqno plus 0 to 3, or a random value
  function automatic logic [31:0] pick_ack();
    int n;
    n = m_pend_lf.size();
    if (n == 0 || $urandom_range(9) == 0) return wrap_abs(m_next) + $urandom_range(3);
    if ($urandom_range(4) == 0) return $urandom;
    return wrap_abs(m_pend_start[$urandom_range(n - 1)]) + $urandom_range(3);
  endfunction

  function automatic tswr_pkg::in_item_t rand_item();
    tswr_pkg::in_item_t it;
    it = mk(3'($urandom_range(7)), 16'($urandom), $urandom, 16'($urandom),
            16'($urandom));
    case ($urandom_range(15))
      0, 1, 2: begin
        it.action = tswr_pkg::ActWrite;
        if ($urandom_range(3) != 0) it.write_count = 16'($urandom_range(3000));
      end
      3, 4, 5: it.action = tswr_pkg::ActFill;
      6, 7, 8, 9: begin
        it.action = tswr_pkg::ActAck;
        it.ack_number = pick_ack();
        if ($urandom_range(3) != 0) it.peer_window_in = 16'($urandom_range(6000));
      end
      10, 11, 12: begin
        it.action = tswr_pkg::ActTick;
        if ($urandom_range(3) != 0) it.elapsed_ms = 16'($urandom_range(2500));
      end
      13: it.action = tswr_pkg::ActEmpty;
      14: if ($urandom_range(5) == 0) it.action = tswr_pkg::ActClose;
      default: ;
    endcase
    return it;
  endfunction

  // random traffic on the running connection; no reset, only register changes between runs
  task automatic run_random(int count);
    repeat (count) send_item(rand_item());
  endtask

  task automatic test_directed();
    send_item(mk(tswr_pkg::ActEmpty, 16'd0, 32'd0, 16'd0, 16'd0));
    send_item(mk(tswr_pkg::ActFill, 16'd0, 32'd0, 16'd0, 16'd0));   // SYN only, window one
    send_item(mk(tswr_pkg::ActTick, 16'd0, 32'd0, 16'd0, 16'hFFFF)); // retransmit SYN
    send_item(mk(tswr_pkg::ActAck, 16'd0, 32'd1, 16'hFFFF, 16'd0));
    send_item(mk(tswr_pkg::ActWrite, 16'hFFFF, 32'd0, 16'd0, 16'd0));
    send_item(mk(tswr_pkg::ActWrite, 16'hFFFF, 32'd0, 16'd0, 16'd0)); // saturates
    send_item(mk(tswr_pkg::ActFill, 16'd0, 32'd0, 16'd0, 16'd0));
    send_item(mk(tswr_pkg::ActAck, 16'd0, 32'hFFFF_FFFF, 16'd0, 16'd0)); // beyond next
    send_item(mk(tswr_pkg::ActAck, 16'd0, wrap_abs(m_next), 16'd0, 16'd0)); // zero window
    send_item(mk(tswr_pkg::ActTick, 16'd0, 32'd0, 16'd0, 16'd0));
    send_item(mk(tswr_pkg::ActTick, 16'd0, 32'd0, 16'd0, 16'hFFFF));
    send_item(mk(tswr_pkg::ActTick, 16'd0, 32'd0, 16'd0, 16'hFFFF)); // no doubling
    send_item(mk(3'd6, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    send_item(mk(3'd7, 16'd0, 32'd0, 16'd0, 16'd0));
    send_item(mk(tswr_pkg::ActAck, 16'd0, wrap_abs(m_next), 16'd40000, 16'd0));
    send_item(mk(tswr_pkg::ActClose, 16'd0, 32'd0, 16'd0, 16'd0));
    send_item(mk(tswr_pkg::ActWrite, 16'd5, 32'd0, 16'd0, 16'd0));   // after close
    send_item(mk(tswr_pkg::ActFill, 16'd0, 32'd0, 16'd0, 16'd0));
    send_item(mk(tswr_pkg::ActAck, 16'd0, wrap_abs(m_next), 16'hFFFF, 16'd0));
    send_item(mk(tswr_pkg::ActFill, 16'd0, 32'd0, 16'd0, 16'd0));
    drain();
  endtask

  task automatic test_random_phases();
    write_reg(tswr_pkg::RegInitialRto, 32'd1);
    write_reg(tswr_pkg::RegInitialSeqno, 32'hFFFF_FF00);
    write_reg(tswr_pkg::RegMaxPayload, 32'd1);
    write_reg(tswr_pkg::RegStreamCap, 32'd1);
    run_random(40);
    drain();
    write_reg(tswr_pkg::RegInitialRto, 32'd65535);
    write_reg(tswr_pkg::RegMaxPayload, 32'd1452);
    write_reg(tswr_pkg::RegStreamCap, 32'd65535);
    idle_pct = 52;
    run_random(60);
    drain();
    write_reg(tswr_pkg::RegInitialRto, $urandom_range(1, 3000));
    write_reg(tswr_pkg::RegInitialSeqno, $urandom);
    write_reg(tswr_pkg::RegMaxPayload, $urandom_range(1, 200));
    idle_pct = 0;
    stall_pct = 52;
    run_random(60);
    drain();
    idle_pct = 23;
    stall_pct = 23;
    write_reg(tswr_pkg::RegStreamCap, $urandom_range(100, 20000));
    run_random(60);
    drain();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  // long receiver hold-off while items keep coming
  task automatic test_backpressure();
    write_reg(tswr_pkg::RegMaxPayload, 32'd1);
    send_item(mk(tswr_pkg::ActWrite, 16'd500, 32'd0, 16'd0, 16'd0));
    send_item(mk(tswr_pkg::ActAck, 16'd0, wrap_abs(m_next), 16'd300, 16'd0));
    hold_off = 1'b1;
    repeat (30) send_item(rand_item());
    drain();
  endtask

  initial begin
    m_rto_init = tswr_pkg::RtoRst;
    m_iseq = tswr_pkg::IseqRst;
    m_max_pay = tswr_pkg::MaxPayRst;
    m_cap = tswr_pkg::CapacityRst;
    m_next = 64'd0; m_flight = 32'd0; m_syn_sent = 0; m_fin_sent = 0; m_closed = 0;
    m_win = 32'd1; m_buf = 32'd0; m_rto = {16'd0, tswr_pkg::RtoRst}; m_tmr = 32'd0;
    m_tmr_on = 0; m_retries = 8'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phases();
    test_backpressure();
    if (mismatches == 0) $display("tcp_sender_window_retransmit_core test passed");
    else $display("tcp_sender_window_retransmit_core test failed");
    $finish;
  end

  // receiver stall
  initial begin
    int held;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        held++;
        if (held >= 400) hold_off = 1'b0;
      end else begin
        out_stall_i <= (stall_pct > 0 && $urandom_range(99) < stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    tswr_pkg::out_item_t exp_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_segs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_data_o);
      end else begin
        exp_o = expected_segs.pop_front();
        if (out_data_o !== exp_o) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", exp_o, out_data_o);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("tcp_sender_window_retransmit_core test failed");
    $finish;
  end

endmodule
